### hdl/work_stealing_task_deque_top_defines.svh
// Assertion macros for the work-stealing task deque.
// Included by the top level; define NO_ASSERTIONS to compile them out.
`ifndef WORK_STEALING_TASK_DEQUE_TOP_DEFINES_SVH
`define WORK_STEALING_TASK_DEQUE_TOP_DEFINES_SVH

`ifndef NO_ASSERTIONS
// Expression must hold at every clock edge out of reset
`define WSTD_ASSERT_ALWAYS(lbl, expr, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (expr)) else $error(msg);
// Consequent must hold in the cycle after the antecedent
`define WSTD_ASSERT_NEXT(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) else $error(msg);
`else
`define WSTD_ASSERT_ALWAYS(lbl, expr, msg)
`define WSTD_ASSERT_NEXT(lbl, ante, cons, msg)
`endif

`endif

### hdl/wstd_pkg.sv
// Shared types, field widths and codes for the work-stealing task deque.
// No dependencies; imported by wstd_ctrl and the top level.
package wstd_pkg;

  // Parameter defaults
  localparam int DEPTH_DEF        = 64;
  localparam int HANDLE_WIDTH_DEF = 16;

  // Field widths of the stream and register ports
  localparam int REQ_W         = 2;
  localparam int TASK_HANDLE_W = 16;
  localparam int OUT_HANDLE_W  = 16;
  localparam int STATUS_W      = 2;
  localparam int ENTRY_COUNT_W = 7;
  localparam int IN_TDATA_W    = 16;
  localparam int IN_TUSER_W    = 2;
  localparam int OUT_TDATA_W   = 32;
  localparam int OUT_TUSER_W   = 1;
  localparam int CFG_ADDR_W    = 3;
  localparam int CFG_DATA_W    = 32;

  typedef logic [REQ_W-1:0]    req_t;
  typedef logic [STATUS_W-1:0] status_t;

  // Request codes
  localparam req_t REQ_ADD    = 2'd0;
  localparam req_t REQ_REMOVE = 2'd1;
  localparam req_t REQ_STEAL  = 2'd2;

  // Status codes
  localparam status_t STATUS_OK    = 2'd0;
  localparam status_t STATUS_EMPTY = 2'd1;
  localparam status_t STATUS_FULL  = 2'd2;

  // Register index (word address bit)
  localparam logic CFG_IDX_QUEUE_MODE = 1'b0;

  // Queue mode values
  localparam logic MODE_LIFO = 1'b0;

  // Decision of the pointer unit for one request
  typedef struct packed {
    logic    take;    // handle read from the store, result follows the read
    status_t status;
  } wstd_rsp_t;

endpackage

### hdl/wstd_ram.sv
// Generic single-write, single-read synchronous RAM with registered read.
// No dependencies.
module wstd_ram #(
  parameter int WIDTH = 16,
  parameter int DEPTH = 64
) (
  input  logic                     clk,
  input  logic                     we,
  input  logic [$clog2(DEPTH)-1:0] waddr,
  input  logic [WIDTH-1:0]         wdata,
  input  logic                     re,
  input  logic [$clog2(DEPTH)-1:0] raddr,
  output logic [WIDTH-1:0]         rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  // Write port
  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
  end

  // Registered read port
  always_ff @(posedge clk) begin
    if (re) begin
      rdata <= mem[raddr];
    end
  end

endmodule

### hdl/wstd_ctrl.sv
// Pointer and count unit of the task deque: decodes a request, steps the
// front and back pointers and issues the RAM access. Uses wstd_pkg.
module wstd_ctrl #(
  parameter int DEPTH        = wstd_pkg::DEPTH_DEF,
  parameter int HANDLE_WIDTH = wstd_pkg::HANDLE_WIDTH_DEF
) (
  input  logic                       clk,
  input  logic                       rst_n,
  input  logic                       go,
  input  wstd_pkg::req_t             req,
  input  logic [HANDLE_WIDTH-1:0]    handle,
  input  logic                       mode,
  output logic                       wen,
  output logic [$clog2(DEPTH)-1:0]   waddr,
  output logic [HANDLE_WIDTH-1:0]    wdata,
  output logic                       ren,
  output logic [$clog2(DEPTH)-1:0]   raddr,
  output wstd_pkg::wstd_rsp_t        rsp,
  output logic [$clog2(DEPTH+1)-1:0] count_nxt
);
  import wstd_pkg::*;

  localparam int PTR_W = $clog2(DEPTH);
  localparam int CNT_W = $clog2(DEPTH + 1);
  localparam logic [PTR_W-1:0] PTR_LAST = PTR_W'(DEPTH - 1);
  localparam logic [CNT_W-1:0] CNT_FULL = CNT_W'(DEPTH);

  logic [PTR_W-1:0] front_r, front_nxt;
  logic [PTR_W-1:0] back_r, back_nxt;
  logic [CNT_W-1:0] count_r;
  logic [PTR_W-1:0] front_inc, front_dec, back_inc, back_dec;
  logic             is_full, is_empty;

  // Circular neighbors of both pointers
  assign front_inc = (front_r == PTR_LAST) ? '0 : front_r + 1'b1;
  assign front_dec = (front_r == '0) ? PTR_LAST : front_r - 1'b1;
  assign back_inc  = (back_r == PTR_LAST) ? '0 : back_r + 1'b1;
  assign back_dec  = (back_r == '0) ? PTR_LAST : back_r - 1'b1;

  assign is_full  = (count_r == CNT_FULL);
  assign is_empty = (count_r == '0);
  assign wdata    = handle;

  // Decode the request and plan the pointer step
  always_comb begin
    front_nxt   = front_r;
    back_nxt    = back_r;
    count_nxt   = count_r;
    wen         = 1'b0;
    waddr       = back_r;
    ren         = 1'b0;
    raddr       = front_r;
    rsp.take    = 1'b0;
    rsp.status  = STATUS_OK;
    unique case (req)
      REQ_ADD: begin
        if (is_full) begin
          rsp.status = STATUS_FULL;
        end else if (mode == MODE_LIFO) begin
          front_nxt = front_dec;
          waddr     = front_dec;
          wen       = go;
          count_nxt = count_r + 1'b1;
        end else begin
          back_nxt  = back_inc;
          waddr     = back_r;
          wen       = go;
          count_nxt = count_r + 1'b1;
        end
      end
      REQ_REMOVE: begin
        if (is_empty) begin
          rsp.status = STATUS_EMPTY;
        end else begin
          raddr     = front_r;
          ren       = go;
          rsp.take  = 1'b1;
          front_nxt = front_inc;
          count_nxt = count_r - 1'b1;
        end
      end
      REQ_STEAL: begin
        if (is_empty) begin
          rsp.status = STATUS_EMPTY;
        end else begin
          raddr     = back_dec;
          ren       = go;
          rsp.take  = 1'b1;
          back_nxt  = back_dec;
          count_nxt = count_r - 1'b1;
        end
      end
      default: begin
        // Unused code: no operation
      end
    endcase
  end

  // Commit the step on an accepted transaction
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      front_r <= '0;
      back_r  <= '0;
      count_r <= '0;
    end else if (go) begin
      front_r <= front_nxt;
      back_r  <= back_nxt;
      count_r <= count_nxt;
    end
  end

endmodule

### hdl/work_stealing_task_deque_top.sv
// Work-stealing task deque: a bounded deque of task handles held in one RAM.
// An add places its handle at the front (queue_mode 0, LIFO) or at the back
// (queue_mode 1, FIFO); a remove takes from the front, a steal from the back.
// Each request transaction yields one result transaction with the taken
// handle, a status (ok, empty, full), the entry count and an empty flag.
// Adds, takes from an empty deque and the unused request code present their
// result in the cycle after the accept; a remove or steal returning a handle
// waits in ST_READ for the registered RAM read. The RAM needs no clearing pass
// after reset: only entries that hold handles are ever read.
// Depends on wstd_pkg, wstd_ctrl, wstd_ram and the assertion macro header.
`include "work_stealing_task_deque_top_defines.svh"

module work_stealing_task_deque_top #(
  parameter int DEPTH        = wstd_pkg::DEPTH_DEF,
  parameter int HANDLE_WIDTH = wstd_pkg::HANDLE_WIDTH_DEF
) (
  input  logic                            clk,
  input  logic                            rst_n,
  // Request stream
  input  logic                            in_tvalid,
  output logic                            in_tready,
  input  logic [wstd_pkg::IN_TDATA_W-1:0] in_tdata,   // [15:0] task_handle
  input  logic [wstd_pkg::IN_TUSER_W-1:0] in_tuser,   // [1:0] req_type
  // Result stream
  output logic                             out_tvalid,
  input  logic                             out_tready,
  // [15:0] out_handle, [17:16] status, [24:18] entry_count, [25] is_empty
  output logic [wstd_pkg::OUT_TDATA_W-1:0] out_tdata,
  output logic [wstd_pkg::OUT_TUSER_W-1:0] out_tuser,  // [0] handle_valid
  // Register port
  input  logic                            cfg_psel,
  input  logic                            cfg_penable,
  input  logic                            cfg_pwrite,
  input  logic [wstd_pkg::CFG_ADDR_W-1:0] cfg_paddr,
  input  logic [wstd_pkg::CFG_DATA_W-1:0] cfg_pwdata,
  output logic [wstd_pkg::CFG_DATA_W-1:0] cfg_prdata,
  output logic                            cfg_pready
);
  import wstd_pkg::*;

  localparam int PTR_W = $clog2(DEPTH);
  localparam int CNT_W = $clog2(DEPTH + 1);
  localparam int PAD_W = OUT_TDATA_W - OUT_HANDLE_W - STATUS_W - ENTRY_COUNT_W - 1;

  // Sequencer states
  localparam logic ST_IDLE = 1'b0;
  localparam logic ST_READ = 1'b1;

  logic                    state_r, state_nxt;
  logic                    mode_r;
  logic                    cfg_wr;
  logic                    accept;
  logic                    wen, ren;
  logic [PTR_W-1:0]        waddr, raddr;
  logic [HANDLE_WIDTH-1:0] wdata, rdata;
  logic [HANDLE_WIDTH-1:0] handle_in;
  wstd_rsp_t               rsp;
  logic [CNT_W-1:0]        count_nxt;

  logic                     out_valid_r, out_valid_nxt;
  logic [OUT_HANDLE_W-1:0]  out_handle_r;
  logic                     out_hvalid_r;
  status_t                  out_status_r;
  logic [ENTRY_COUNT_W-1:0] out_count_r;
  logic                     out_empty_r;

  // Register port: single mode register, always ready
  assign cfg_pready = 1'b1;
  assign cfg_wr     = cfg_psel & cfg_penable & cfg_pwrite & cfg_pready
                    & (cfg_paddr[2] == CFG_IDX_QUEUE_MODE);
  assign cfg_prdata = (cfg_paddr[2] == CFG_IDX_QUEUE_MODE)
                    ? {{(CFG_DATA_W-1){1'b0}}, mode_r} : '0;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      mode_r <= MODE_LIFO;
    end else if (cfg_wr) begin
      mode_r <= cfg_pwdata[0];
    end
  end

  // Take a request while idle and the result register is free or draining
  assign in_tready = (state_r == ST_IDLE) && (!out_valid_r || out_tready);
  assign accept    = in_tvalid & in_tready;
  assign handle_in = HANDLE_WIDTH'(in_tdata[TASK_HANDLE_W-1:0]);

  wstd_ctrl #(
    .DEPTH        (DEPTH),
    .HANDLE_WIDTH (HANDLE_WIDTH)
  ) u_ctrl (
    .clk       (clk),
    .rst_n     (rst_n),
    .go        (accept),
    .req       (in_tuser[REQ_W-1:0]),
    .handle    (handle_in),
    .mode      (mode_r),
    .wen       (wen),
    .waddr     (waddr),
    .wdata     (wdata),
    .ren       (ren),
    .raddr     (raddr),
    .rsp       (rsp),
    .count_nxt (count_nxt)
  );

  wstd_ram #(
    .WIDTH (HANDLE_WIDTH),
    .DEPTH (DEPTH)
  ) u_store (
    .clk   (clk),
    .we    (wen),
    .waddr (waddr),
    .wdata (wdata),
    .re    (ren),
    .raddr (raddr),
    .rdata (rdata)
  );

  // Wait in ST_READ for the RAM when a handle is taken
  always_comb begin
    state_nxt = state_r;
    unique case (state_r)
      ST_IDLE: begin
        if (accept && rsp.take) begin
          state_nxt = ST_READ;
        end
      end
      ST_READ: state_nxt = ST_IDLE;
      default: state_nxt = ST_IDLE;
    endcase
  end

  // Result valid: drop on drain, raise on a finished request
  always_comb begin
    out_valid_nxt = out_valid_r;
    if (out_valid_r && out_tready) begin
      out_valid_nxt = 1'b0;
    end
    if ((accept && !rsp.take) || (state_r == ST_READ)) begin
      out_valid_nxt = 1'b1;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= ST_IDLE;
      out_valid_r <= 1'b0;
    end else begin
      state_r     <= state_nxt;
      out_valid_r <= out_valid_nxt;
    end
  end

  // Result payload: status and count at accept, handle after the read
  always_ff @(posedge clk) begin
    if (accept) begin
      out_handle_r <= '0;
      out_hvalid_r <= 1'b0;
      out_status_r <= rsp.status;
      out_count_r  <= ENTRY_COUNT_W'(count_nxt);
      out_empty_r  <= (count_nxt == '0);
    end else if (state_r == ST_READ) begin
      out_handle_r <= OUT_HANDLE_W'(rdata);
      out_hvalid_r <= 1'b1;
    end
  end

  assign out_tvalid = out_valid_r;
  assign out_tdata  = {{PAD_W{1'b0}}, out_empty_r, out_count_r, out_status_r, out_handle_r};
  assign out_tuser  = out_hvalid_r;

  // Checks
  `WSTD_ASSERT_ALWAYS(a_count_bound, count_nxt <= CNT_W'(DEPTH), "entry count above depth")
  `WSTD_ASSERT_NEXT(a_take_waits, accept && rsp.take, (state_r == ST_READ) && !out_valid_r, "take did not wait for RAM read")
  `WSTD_ASSERT_NEXT(a_read_result, state_r == ST_READ, out_valid_r && out_hvalid_r && (out_status_r == STATUS_OK), "taken handle not presented")
  `WSTD_ASSERT_NEXT(a_fast_result, accept && !rsp.take, out_valid_r && !out_hvalid_r && (state_r == ST_IDLE), "one-cycle request not presented")

endmodule
